// ===== hdl/kl_pkg.sv =====
// Package: shared types, constants and round functions of the KeeLoq pipeline.
`default_nettype none

package kl_pkg;

  // Cipher geometry
  localparam int unsigned KL_ROUND_COUNT      = 528;
  localparam int unsigned KL_ROUNDS_PER_STAGE = 8;
  localparam logic [31:0] KL_NLF_TABLE        = 32'h3A5C742E;

  // Key derivation constants
  localparam logic [31:0] KL_SERIAL_MASK  = 32'h0FFFFFFF;
  localparam logic [31:0] KL_NORMAL_LO    = 32'h20000000;
  localparam logic [31:0] KL_NORMAL_HI    = 32'h60000000;
  localparam logic [15:0] KL_SEED_TAG     = 16'h544D;
  localparam logic [63:0] KL_MAGIC3_KMASK = 64'hFFFFFFFFFF000000;
  localparam logic [31:0] KL_MAGIC3_SMASK = 32'h00FFFFFF;

  // Mode codes of an input beat
  typedef enum logic [3:0] {
    MODE_ENC    = 4'd0,
    MODE_DEC    = 4'd1,
    MODE_NORMAL = 4'd2,
    MODE_SECURE = 4'd3,
    MODE_XOR    = 4'd4,
    MODE_SEED   = 4'd5,
    MODE_MAGIC1 = 4'd6,
    MODE_MAGIC2 = 4'd7,
    MODE_MAGIC3 = 4'd8
  } kl_mode_t;

  // What the round stages do with the two lanes
  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_ENC  = 2'd1,
    OP_DEC  = 2'd2
  } kl_op_t;

  // Item traveling down the pipeline
  typedef struct packed {
    kl_op_t      op;
    logic        half;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] key;
  } kl_item_t;

  function automatic logic kl_nlf(input logic a, input logic b, input logic c,
                                  input logic d, input logic e);
    logic [4:0] idx;
    idx = {e, d, c, b, a};
    return KL_NLF_TABLE[idx];
  endfunction

  // One round in the direction that op selects; pass leaves the word alone
  function automatic logic [31:0] kl_round(input kl_op_t op, input logic [31:0] x,
                                           input logic kb_enc, input logic kb_dec);
    logic fb;
    logic [31:0] y;
    fb = 1'b0;
    y  = x;
    unique case (op)
      OP_ENC: begin
        fb = x[0] ^ x[16] ^ kb_enc ^ kl_nlf(x[1], x[9], x[20], x[26], x[31]);
        y  = {fb, x[31:1]};
      end
      OP_DEC: begin
        fb = x[15] ^ x[31] ^ kb_dec ^ kl_nlf(x[0], x[8], x[19], x[25], x[30]);
        y  = {x[30:0], fb};
      end
      default: y = x;
    endcase
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/kl_if.sv =====
// Interfaces: request and result channels with valid/ready handshake.
`default_nettype none

interface kl_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [63:0] key;

  modport source (output valid, output mode, output word_a, output word_b,
                  output key, input ready);
  modport sink   (input valid, input mode, input word_a, input word_b,
                  input key, output ready);
endinterface

interface kl_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

// ===== hdl/keeloq_cipher_and_key_learning.sv =====
// An accepted beat passes the input register, the round stages and the output register to the result.
// Throughput: one beat per cycle while no result waits unaccepted; each round stage runs 8 KeeLoq rounds on two lanes.
// The whole pipeline advances together and holds while a result waits unaccepted.
// Reset (synchronous, active low) clears the valid bits; payload is not reset.
`default_nettype none

module keeloq_cipher_and_key_learning #(
  parameter int unsigned ROUND_COUNT = kl_pkg::KL_ROUND_COUNT
) (
  input wire logic clk,
  input wire logic rst_n,
  kl_req_if.sink   in_chan,
  kl_rsp_if.source out_chan
);
  import kl_pkg::*;

  localparam int unsigned NSTAGE = (ROUND_COUNT + KL_ROUNDS_PER_STAGE - 1) /
                                   KL_ROUNDS_PER_STAGE;

  logic              adv;
  logic [NSTAGE:0]   stg_vld;
  kl_item_t          stg_item [0:NSTAGE];
  logic              out_vld;
  logic [63:0]       out_result;

  // Advance whenever the output register is free or being drained
  assign adv           = !out_vld || out_chan.ready;
  assign in_chan.ready = adv;

  kl_prep u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_chan.valid),
    .mode   (in_chan.mode),
    .word_a (in_chan.word_a),
    .word_b (in_chan.word_b),
    .key    (in_chan.key),
    .vld_r  (stg_vld[0]),
    .item_r (stg_item[0])
  );

  for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
    kl_round_stage #(
      .BASE        (i * KL_ROUNDS_PER_STAGE),
      .ROUND_COUNT (ROUND_COUNT)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_vld  (stg_vld[i]),
      .in_item (stg_item[i]),
      .vld_r   (stg_vld[i+1]),
      .item_r  (stg_item[i+1])
    );
  end

  kl_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (stg_vld[NSTAGE]),
    .in_item  (stg_item[NSTAGE]),
    .vld_r    (out_vld),
    .result_r (out_result)
  );

  assign out_chan.valid  = out_vld;
  assign out_chan.result = out_result;

  // An accepted beat lands in the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> stg_vld[0])
    else $error("accepted beat missing from first stage");

  // A stall only happens while a result is held
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> out_vld)
    else $error("pipeline stalled with empty output register");

  // A stall freezes every stage valid bit
  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(stg_vld))
    else $error("stage valid changed during stall");

  // The last stage drains into the output register
  a_drain_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && stg_vld[NSTAGE] |=> out_vld)
    else $error("last stage beat lost before output");

endmodule

`default_nettype wire

// ===== hdl/kl_prep.sv =====
// Input stage: decode the mode into lane words and lane operation.
`default_nettype none

module kl_prep (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic        in_vld,
  input  wire logic [3:0]  mode,
  input  wire logic [31:0] word_a,
  input  wire logic [31:0] word_b,
  input  wire logic [63:0] key,
  output logic             vld_r,
  output kl_pkg::kl_item_t item_r
);
  import kl_pkg::*;

  logic [31:0] ser;
  logic [7:0]  sum;
  kl_item_t    item_nxt;

  assign ser = word_a & KL_SERIAL_MASK;
  assign sum = ser[7:0] + ser[15:8];

  // Load lanes per mode
  always_comb begin
    item_nxt.op   = OP_PASS;
    item_nxt.half = 1'b0;
    item_nxt.hi   = '0;
    item_nxt.lo   = '0;
    item_nxt.key  = key;
    unique case (kl_mode_t'(mode))
      MODE_ENC: begin
        item_nxt.op   = OP_ENC;
        item_nxt.half = 1'b1;
        item_nxt.lo   = word_a;
      end
      MODE_DEC: begin
        item_nxt.op   = OP_DEC;
        item_nxt.half = 1'b1;
        item_nxt.lo   = word_a;
      end
      MODE_NORMAL: begin
        item_nxt.op = OP_DEC;
        item_nxt.hi = ser | KL_NORMAL_HI;
        item_nxt.lo = ser | KL_NORMAL_LO;
      end
      MODE_SECURE: begin
        item_nxt.op = OP_DEC;
        item_nxt.hi = ser;
        item_nxt.lo = word_b;
      end
      MODE_XOR: begin
        item_nxt.hi = ser ^ key[63:32];
        item_nxt.lo = ser ^ key[31:0];
      end
      MODE_SEED: begin
        item_nxt.op = OP_ENC;
        item_nxt.hi = word_b;
        item_nxt.lo = {word_b[31:16], KL_SEED_TAG};
      end
      MODE_MAGIC1: begin
        item_nxt.hi = {ser[23:0], sum};
        item_nxt.lo = key[31:0];
      end
      MODE_MAGIC2: begin
        item_nxt.hi = {word_a[7:0], word_a[15:8], word_a[23:16], word_a[31:24]};
        item_nxt.lo = key[31:0];
      end
      MODE_MAGIC3: begin
        item_nxt.hi = key[63:32] & KL_MAGIC3_KMASK[63:32];
        item_nxt.lo = (key[31:0] & KL_MAGIC3_KMASK[31:0]) | (word_a & KL_MAGIC3_SMASK);
      end
      default: begin
        item_nxt.hi = '0;
        item_nxt.lo = '0;
      end
    endcase
  end

  // Hold valid under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kl_round_stage.sv =====
// Round stage: a fixed slice of cipher rounds applied to both lanes.
`default_nettype none

module kl_round_stage #(
  parameter int unsigned BASE        = 0,
  parameter int unsigned ROUND_COUNT = kl_pkg::KL_ROUND_COUNT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire kl_pkg::kl_item_t in_item,
  output logic                  vld_r,
  output kl_pkg::kl_item_t      item_r
);
  import kl_pkg::*;

  localparam int unsigned RPS = KL_ROUNDS_PER_STAGE;

  logic [31:0] hi_c [0:RPS];
  logic [31:0] lo_c [0:RPS];
  kl_item_t    item_nxt;

  assign hi_c[0] = in_item.hi;
  assign lo_c[0] = in_item.lo;

  // Chain the rounds of this slice; rounds past the count pass through
  for (genvar j = 0; j < RPS; j++) begin : g_round
    localparam int unsigned R      = BASE + j;
    localparam logic [5:0]  EI     = 6'(R);
    localparam logic [5:0]  DI     = 6'(32'd15 - R);
    localparam bit          ACTIVE = (R < ROUND_COUNT);
    if (ACTIVE) begin : g_on
      assign hi_c[j+1] = kl_round(in_item.op, hi_c[j], in_item.key[EI], in_item.key[DI]);
      assign lo_c[j+1] = kl_round(in_item.op, lo_c[j], in_item.key[EI], in_item.key[DI]);
    end else begin : g_off
      assign hi_c[j+1] = hi_c[j];
      assign lo_c[j+1] = lo_c[j];
    end
  end

  always_comb begin
    item_nxt    = in_item;
    item_nxt.hi = hi_c[RPS];
    item_nxt.lo = lo_c[RPS];
  end

  // Hold valid under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kl_pack.sv =====
// Output stage: assemble the 64-bit result and hold it for the sink.
`default_nettype none

module kl_pack (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire kl_pkg::kl_item_t in_item,
  output logic                  vld_r,
  output logic [63:0]           result_r
);
  import kl_pkg::*;

  logic [63:0] result_nxt;

  // Single-block modes clear the upper word
  assign result_nxt = in_item.half ? {32'd0, in_item.lo} : {in_item.hi, in_item.lo};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the KeeLoq pipeline: random and directed beats checked in order.
module tb;
  import kl_pkg::*;

  localparam int CIPHER_ROUNDS = KL_ROUND_COUNT;
  localparam int RANDOM_BEATS  = 2000;
  localparam int DRAIN_EVERY   = 500;
  localparam int TAIL_CYCLES   = 100;
  localparam int STALL_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 50;

  // Mode codes with no operation behind them
  localparam logic [3:0] MODE_UNUSED_LO  = 4'd9;
  localparam logic [3:0] MODE_UNUSED_MID = 4'd12;
  localparam logic [3:0] MODE_UNUSED_HI  = 4'd15;

  typedef struct {
    logic [3:0]  mode;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [63:0] key;
    bit          drain;
  } request_t;

  logic clk;
  logic rst_n;

  kl_req_if req ();
  kl_rsp_if rsp ();

  keeloq_cipher_and_key_learning dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req),
    .out_chan (rsp)
  );

  request_t    pending_requests[$];
  logic [63:0] expected_results[$];
  request_t    next_req;

  int mismatch_count = 0;
  int results_checked = 0;
  int mode_hits[16];
  int burst_left = 1;
  int gap_left = 0;
  int ready_style = 0;
  int style_left = 0;
  int stall_left = 0;
  int ready_phase = 0;
  int idle_cycles = 0;

  // Forward KeeLoq rounds; key bit index wraps every 64 rounds
  function automatic logic [31:0] keeloq_encrypt(logic [31:0] blk, logic [63:0] k);
    logic [31:0] x;
    logic [4:0]  sel;
    logic        fb;
    x = blk;
    for (int r = 0; r < CIPHER_ROUNDS; r++) begin
      sel = {x[31], x[26], x[20], x[9], x[1]};
      fb  = x[0] ^ x[16] ^ k[r & 63] ^ KL_NLF_TABLE[sel];
      x   = {fb, x[31:1]};
    end
    return x;
  endfunction

  // Inverse rounds; key bit index runs down from 15 and wraps
  function automatic logic [31:0] keeloq_decrypt(logic [31:0] blk, logic [63:0] k);
    logic [31:0] x;
    logic [4:0]  sel;
    logic        fb;
    x = blk;
    for (int r = 0; r < CIPHER_ROUNDS; r++) begin
      sel = {x[30], x[25], x[19], x[8], x[0]};
      fb  = x[15] ^ x[31] ^ k[(15 - r) & 63] ^ KL_NLF_TABLE[sel];
      x   = {x[30:0], fb};
    end
    return x;
  endfunction

  // Result of one beat for every mode code
  function automatic logic [63:0] keeloq_predict(logic [3:0] mode, logic [31:0] wa,
                                                 logic [31:0] wb, logic [63:0] k);
    logic [31:0] s;
    logic [7:0]  sum;
    logic [63:0] res;
    s   = wa & KL_SERIAL_MASK;
    sum = s[7:0] + s[15:8];
    res = '0;
    case (mode)
      MODE_ENC:    res = {32'h0, keeloq_encrypt(wa, k)};
      MODE_DEC:    res = {32'h0, keeloq_decrypt(wa, k)};
      MODE_NORMAL: res = {keeloq_decrypt(s | KL_NORMAL_HI, k),
                          keeloq_decrypt(s | KL_NORMAL_LO, k)};
      MODE_SECURE: res = {keeloq_decrypt(s, k), keeloq_decrypt(wb, k)};
      MODE_XOR:    res = {s, s} ^ k;
      MODE_SEED:   res = {keeloq_encrypt(wb, k), keeloq_encrypt({wb[31:16], KL_SEED_TAG}, k)};
      MODE_MAGIC1: res = {s[23:0], sum, k[31:0]};
      MODE_MAGIC2: res = {wa[7:0], wa[15:8], wa[23:16], wa[31:24], k[31:0]};
      MODE_MAGIC3: res = (k & KL_MAGIC3_KMASK) | {32'h0, wa & KL_MAGIC3_SMASK};
      default:     res = '0;
    endcase
    return res;
  endfunction

  function automatic request_t make_request(logic [3:0] mode, logic [31:0] wa,
                                            logic [31:0] wb, logic [63:0] k, bit drain);
    request_t r;
    r.mode   = mode;
    r.word_a = wa;
    r.word_b = wb;
    r.key    = k;
    r.drain  = drain;
    return r;
  endfunction

  // Mostly random words, with the all-zero and all-one extremes mixed in
  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'h0;
    if (roll == 1) return 32'hFFFFFFFF;
    return $urandom();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Send side: accept beats, predict them, present the next one in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_results.push_back(keeloq_predict(req.mode, req.word_a, req.word_b, req.key));
        mode_hits[req.mode]++;
      end
      if (!req.valid || req.ready) begin
        if (pending_requests.size() == 0 ||
            (pending_requests[0].drain && expected_results.size() != 0)) begin
          req.valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else begin
          next_req = pending_requests.pop_front();
          req.valid  <= 1'b1;
          req.mode   <= next_req.mode;
          req.word_a <= next_req.word_a;
          req.word_b <= next_req.word_b;
          req.key    <= next_req.key;
          if (burst_left > 1) begin
            burst_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            // long stretch with no gaps at all
            burst_left = $urandom_range(100, 300);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end
    end
  end

  // Receive side: switch among always-ready, coin-flip, periodic and long-stall patterns
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 3);
        style_left  = $urandom_range(64, 256);
      end
      style_left--;
      ready_phase++;
      case (ready_style)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 1) == 1);
        2: rsp.ready <= ((ready_phase & 3) == 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
          end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      results_checked++;
      if (expected_results.size() == 0)
        report_mismatch("result with nothing expected", rsp.result, 64'h0);
      else if (rsp.result !== expected_results[0]) begin
        report_mismatch("result", rsp.result, expected_results[0]);
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // Drop the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] rand_mode;
    int cipher_cnt;
    int derive_cnt;
    int pack_cnt;
    int unused_cnt;

    rst_n      = 1'b0;
    req.valid  = 1'b0;
    req.mode   = '0;
    req.word_a = '0;
    req.word_b = '0;
    req.key    = '0;
    rsp.ready  = 1'b0;
    foreach (mode_hits[i]) mode_hits[i] = 0;

    // Directed: extremes of each operation, masked serial bits, ignored operands
    pending_requests.push_back(make_request(MODE_ENC, 32'h0, 32'h0, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_ENC, '1, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_DEC, 32'h0, 32'h0, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_DEC, '1, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_ENC, 32'h5A5A5A5A, 32'h0,
                                            64'h0123456789ABCDEF, 0));
    pending_requests.push_back(make_request(MODE_DEC, 32'h5A5A5A5A, 32'h0,
                                            64'h0123456789ABCDEF, 0));
    pending_requests.push_back(make_request(MODE_NORMAL, '1, 32'h0, 64'hFEDCBA9876543210, 0));
    pending_requests.push_back(make_request(MODE_NORMAL, 32'h0, '1, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_SECURE, '1, 32'h0, '1, 0));
    pending_requests.push_back(make_request(MODE_SECURE, 32'h0, '1, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_XOR, '1, 32'h0, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_XOR, 32'hF0000000, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_SEED, 32'h0, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_SEED, '1, 32'h0, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_MAGIC1, 32'h0000FFFF, '1, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_MAGIC1, '1, 32'h0, '1, 0));
    pending_requests.push_back(make_request(MODE_MAGIC2, 32'h11223344, 32'h0, '1, 0));
    pending_requests.push_back(make_request(MODE_MAGIC2, '1, '1, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_MAGIC3, '1, 32'h0, 64'h0, 0));
    pending_requests.push_back(make_request(MODE_MAGIC3, 32'h0, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_UNUSED_LO, '1, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_UNUSED_HI, '1, '1, '1, 0));
    pending_requests.push_back(make_request(MODE_UNUSED_MID, 32'h0, 32'h0, 64'h0, 0));

    // Random: mostly defined modes, some unused codes; hold the sender to drain now and then
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if ($urandom_range(0, 9) == 0)
        rand_mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
      else
        rand_mode = 4'($urandom_range(MODE_ENC, MODE_MAGIC3));
      pending_requests.push_back(make_request(rand_mode, pick_word(), pick_word(),
                                              {pick_word(), pick_word()},
                                              (n % DRAIN_EVERY) == 0));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the last beat to go in, then for every result and a quiet tail
    while (pending_requests.size() != 0 || req.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    cipher_cnt = mode_hits[MODE_ENC] + mode_hits[MODE_DEC];
    derive_cnt = mode_hits[MODE_NORMAL] + mode_hits[MODE_SECURE] +
                 mode_hits[MODE_XOR] + mode_hits[MODE_SEED];
    pack_cnt   = mode_hits[MODE_MAGIC1] + mode_hits[MODE_MAGIC2] + mode_hits[MODE_MAGIC3];
    unused_cnt = 0;
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++) unused_cnt += mode_hits[m];
    $display("Covered %0d cipher, %0d key learning, %0d serial packing, %0d unused-code beats",
             cipher_cnt, derive_cnt, pack_cnt, unused_cnt);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
